>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FCT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/fct_pkg.sv
// ---------------------------------------------------------------------------
// fct_pkg
// Types and constants of the cluster chain table engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

	localparam int CLUS_W = 28;
	localparam int ENTRY_W = 32;

	localparam logic [CLUS_W-1:0] EOC_MIN = 28'hFFFFFF8;
	localparam logic [ENTRY_W-1:0] EOC_MARK = 32'h0FFFFFFF;
	localparam logic [CLUS_W-1:0] MIN_CLUSTER = 28'd2;

	localparam logic [2:0] ACT_READ = 3'd0;
	localparam logic [2:0] ACT_WRITE = 3'd1;
	localparam logic [2:0] ACT_ALLOC = 3'd2;
	localparam logic [2:0] ACT_FREE = 3'd3;
	localparam logic [2:0] ACT_COUNT = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;
	localparam logic [1:0] ST_LIMIT = 2'd3;

	localparam logic [1:0] REG_FIRST = 2'd0;
	localparam logic [1:0] REG_LAST = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	localparam logic [CLUS_W-1:0] RST_FIRST = 28'd2;
	localparam logic [CLUS_W-1:0] RST_LAST = 28'd4097;
	localparam logic [CLUS_W-1:0] RST_COUNT = 28'd4096;

	typedef struct packed {
		logic [2:0] action;
		logic [CLUS_W-1:0] cluster;
		logic [CLUS_W-1:0] previous_cluster;
		logic [ENTRY_W-1:0] entry_value;
	} req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] result_value;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic [CLUS_W-1:0] first_valid_cluster;
		logic [CLUS_W-1:0] last_valid_cluster;
		logic [CLUS_W-1:0] cluster_count;
	} cfg_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISP,
		S_RDWAIT,
		S_WR2,
		S_SCAN,
		S_CHAIN,
		S_CHWAIT
	} state_t;

endpackage

`default_nettype wire

>>> rtl/core/fat_cluster_table_engine.sv
// Each request is accepted in idle and dispatched. A read waits for the registered read data;
// a free that terminates a previous cluster, and an allocate that links, add a second write;
// allocate scans entries first-fit and count chain reads each in-range link. Refused requests,
// out-of-range reads and a zero chain start finish at dispatch. Throughput: one request at a
// time; the next is accepted in the cycle of the strobe. The single table memory port sets the
// pace. After reset the table is swept to zero with busy high; the receiver cannot stall.
// ---------------------------------------------------------------------------
// fat_cluster_table_engine
// Cluster chain table with read, write, first-fit allocate, free and chain count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fat_cluster_table_engine #(
	parameter int TABLE_ENTRIES = 4096
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  fct_pkg::req_t                   req,
	output logic                            busy,
	output logic                            done,
	output fct_pkg::rsp_t                   rsp,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [fct_pkg::CLUS_W-1:0] cfg_data
);

	localparam int AW = $clog2(TABLE_ENTRIES);

	fct_pkg::cfg_t cfg;
	logic mem_we;
	logic [AW-1:0] mem_addr;
	logic [fct_pkg::ENTRY_W-1:0] mem_wdata;
	logic [fct_pkg::ENTRY_W-1:0] mem_rdata;

	fct_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fct_table_ram #(
		.DEPTH (TABLE_ENTRIES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	fct_seq #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.AW            (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

endmodule

`default_nettype wire

>>> rtl/core/fct_cfg_regs.sv
// ---------------------------------------------------------------------------
// fct_cfg_regs
// Configuration registers: cluster range limits and allocation scan length.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fct_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [fct_pkg::CLUS_W-1:0] cfg_data,
	output fct_pkg::cfg_t                   cfg
);

	fct_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_valid_cluster <= fct_pkg::RST_FIRST;
			cfg_q.last_valid_cluster <= fct_pkg::RST_LAST;
			cfg_q.cluster_count <= fct_pkg::RST_COUNT;
		end else if (cfg_we) begin
			case (cfg_index)
				fct_pkg::REG_FIRST: cfg_q.first_valid_cluster <= cfg_data;
				fct_pkg::REG_LAST: cfg_q.last_valid_cluster <= cfg_data;
				fct_pkg::REG_COUNT: cfg_q.cluster_count <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/fct_table_ram.sv
// ---------------------------------------------------------------------------
// fct_table_ram
// Single-port chain table memory, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fct_table_ram #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               addr,
	input  wire logic [fct_pkg::ENTRY_W-1:0] wdata,
	output logic      [fct_pkg::ENTRY_W-1:0] rdata
);

	logic [fct_pkg::ENTRY_W-1:0] mem [DEPTH];
	logic [fct_pkg::ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/fct_seq.sv
// ---------------------------------------------------------------------------
// fct_seq
// Request sequencer: clears the table, then reads and writes table entries
// as each request needs them and drives the result strobe.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fct_seq #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int AW = 12
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  fct_pkg::cfg_t                    cfg,
	input  wire logic                        start,
	input  fct_pkg::req_t                    req,
	output logic                             busy,
	output logic                             done,
	output fct_pkg::rsp_t                    rsp,
	output logic                             mem_we,
	output logic      [AW-1:0]               mem_addr,
	output logic      [fct_pkg::ENTRY_W-1:0] mem_wdata,
	input  wire logic [fct_pkg::ENTRY_W-1:0] mem_rdata
);

	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [fct_pkg::CLUS_W-1:0] TE28 = fct_pkg::CLUS_W'(TABLE_ENTRIES);
	localparam logic [CW-1:0] TE_CNT = CW'(TABLE_ENTRIES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

	function automatic logic in_rng(input logic [fct_pkg::CLUS_W-1:0] c,
	                                input fct_pkg::cfg_t cf);
		logic ok;
		ok = (c >= fct_pkg::MIN_CLUSTER) && (c >= cf.first_valid_cluster) &&
		     (c <= cf.last_valid_cluster) && ((c - fct_pkg::MIN_CLUSTER) < TE28);
		return ok;
	endfunction

	function automatic logic [AW-1:0] slot(input logic [fct_pkg::CLUS_W-1:0] c);
		logic [fct_pkg::CLUS_W-1:0] d;
		d = c - fct_pkg::MIN_CLUSTER;
		return d[AW-1:0];
	endfunction

	fct_pkg::state_t state_q, state_d;
	fct_pkg::req_t req_q;

	logic [AW-1:0] clr_q, clr_d;
	logic [CW-1:0] k_q, k_d;
	logic [CW-1:0] lim_q, lim_d;
	logic v_s1, v_d;
	logic [AW-1:0] idx_s1, idx_d;
	logic [fct_pkg::CLUS_W-1:0] c_q, c_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] w2a_q, w2a_d;
	logic [fct_pkg::ENTRY_W-1:0] w2d_q, w2d_d;
	logic [fct_pkg::ENTRY_W-1:0] res_q, res_d;

	logic fin;
	logic [fct_pkg::ENTRY_W-1:0] fin_res;
	logic [1:0] fin_st;
	logic done_q;
	fct_pkg::rsp_t rsp_q;

	logic [fct_pkg::CLUS_W-1:0] scan_clus;
	logic prev_bad;

	assign scan_clus = fct_pkg::CLUS_W'(idx_s1) + fct_pkg::MIN_CLUSTER;
	assign prev_bad = (req_q.previous_cluster != '0) && !in_rng(req_q.previous_cluster, cfg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fct_pkg::S_CLEAR;
			clr_q <= '0;
			v_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			v_s1 <= v_d;
			done_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fct_pkg::S_IDLE && start) begin
			req_q <= req;
		end
		k_q <= k_d;
		lim_q <= lim_d;
		idx_s1 <= idx_d;
		c_q <= c_d;
		cnt_q <= cnt_d;
		w2a_q <= w2a_d;
		w2d_q <= w2d_d;
		res_q <= res_d;
		if (fin) begin
			rsp_q.result_value <= fin_res;
			rsp_q.status <= fin_st;
		end
	end

	always_comb begin
		state_d = state_q;
		clr_d = clr_q;
		k_d = k_q;
		lim_d = lim_q;
		v_d = 1'b0;
		idx_d = idx_s1;
		c_d = c_q;
		cnt_d = cnt_q;
		w2a_d = w2a_q;
		w2d_d = w2d_q;
		res_d = res_q;
		mem_we = 1'b0;
		mem_addr = '0;
		mem_wdata = '0;
		fin = 1'b0;
		fin_res = '0;
		fin_st = fct_pkg::ST_OK;

		case (state_q)
			fct_pkg::S_CLEAR: begin
				mem_we = 1'b1;
				mem_addr = clr_q;
				if (clr_q == LAST_ADDR) begin
					state_d = fct_pkg::S_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			fct_pkg::S_IDLE: begin
				if (start) begin
					state_d = fct_pkg::S_DISP;
				end
			end
			fct_pkg::S_DISP: begin
				case (req_q.action)
					fct_pkg::ACT_READ: begin
						if (in_rng(req_q.cluster, cfg)) begin
							mem_addr = slot(req_q.cluster);
							state_d = fct_pkg::S_RDWAIT;
						end else begin
							fin = 1'b1;
							state_d = fct_pkg::S_IDLE;
						end
					end
					fct_pkg::ACT_WRITE: begin
						fin = 1'b1;
						state_d = fct_pkg::S_IDLE;
						if (in_rng(req_q.cluster, cfg)) begin
							mem_we = 1'b1;
							mem_addr = slot(req_q.cluster);
							mem_wdata = req_q.entry_value;
						end else begin
							fin_st = fct_pkg::ST_RANGE;
						end
					end
					fct_pkg::ACT_ALLOC: begin
						if (prev_bad) begin
							fin = 1'b1;
							fin_st = fct_pkg::ST_RANGE;
							state_d = fct_pkg::S_IDLE;
						end else begin
							k_d = '0;
							lim_d = (cfg.cluster_count < TE28) ? CW'(cfg.cluster_count) : TE_CNT;
							state_d = fct_pkg::S_SCAN;
						end
					end
					fct_pkg::ACT_FREE: begin
						if (!in_rng(req_q.cluster, cfg) || prev_bad) begin
							fin = 1'b1;
							fin_st = fct_pkg::ST_RANGE;
							state_d = fct_pkg::S_IDLE;
						end else if (req_q.previous_cluster != '0) begin
							// terminate the previous cluster first, release this one next
							mem_we = 1'b1;
							mem_addr = slot(req_q.previous_cluster);
							mem_wdata = fct_pkg::EOC_MARK;
							w2a_d = slot(req_q.cluster);
							w2d_d = '0;
							res_d = '0;
							state_d = fct_pkg::S_WR2;
						end else begin
							mem_we = 1'b1;
							mem_addr = slot(req_q.cluster);
							fin = 1'b1;
							state_d = fct_pkg::S_IDLE;
						end
					end
					fct_pkg::ACT_COUNT: begin
						c_d = req_q.cluster;
						cnt_d = '0;
						if (req_q.cluster == '0) begin
							fin = 1'b1;
							state_d = fct_pkg::S_IDLE;
						end else begin
							state_d = fct_pkg::S_CHAIN;
						end
					end
					default: begin
						fin = 1'b1;
						fin_st = fct_pkg::ST_RANGE;
						state_d = fct_pkg::S_IDLE;
					end
				endcase
			end
			fct_pkg::S_RDWAIT: begin
				fin = 1'b1;
				fin_res = mem_rdata;
				state_d = fct_pkg::S_IDLE;
			end
			fct_pkg::S_WR2: begin
				mem_we = 1'b1;
				mem_addr = w2a_q;
				mem_wdata = w2d_q;
				fin = 1'b1;
				fin_res = res_q;
				state_d = fct_pkg::S_IDLE;
			end
			fct_pkg::S_SCAN: begin
				// check the entry read last cycle while issuing the next read
				if (v_s1 && mem_rdata == '0 && in_rng(scan_clus, cfg)) begin
					if (req_q.previous_cluster != '0) begin
						mem_we = 1'b1;
						mem_addr = slot(req_q.previous_cluster);
						mem_wdata = fct_pkg::ENTRY_W'(scan_clus);
						w2a_d = idx_s1;
						w2d_d = fct_pkg::EOC_MARK;
						res_d = fct_pkg::ENTRY_W'(scan_clus);
						state_d = fct_pkg::S_WR2;
					end else begin
						mem_we = 1'b1;
						mem_addr = idx_s1;
						mem_wdata = fct_pkg::EOC_MARK;
						fin = 1'b1;
						fin_res = fct_pkg::ENTRY_W'(scan_clus);
						state_d = fct_pkg::S_IDLE;
					end
				end else if (k_q < lim_q) begin
					mem_addr = k_q[AW-1:0];
					v_d = 1'b1;
					idx_d = k_q[AW-1:0];
					k_d = k_q + 1'b1;
				end else begin
					fin = 1'b1;
					fin_st = fct_pkg::ST_NOSPACE;
					state_d = fct_pkg::S_IDLE;
				end
			end
			fct_pkg::S_CHAIN: begin
				if (c_q >= fct_pkg::EOC_MIN) begin
					fin = 1'b1;
					fin_res = fct_pkg::ENTRY_W'(cnt_q);
					state_d = fct_pkg::S_IDLE;
				end else if (cnt_q == TE_CNT) begin
					fin = 1'b1;
					fin_res = fct_pkg::ENTRY_W'(cnt_q);
					fin_st = fct_pkg::ST_LIMIT;
					state_d = fct_pkg::S_IDLE;
				end else if (in_rng(c_q, cfg)) begin
					mem_addr = slot(c_q);
					state_d = fct_pkg::S_CHWAIT;
				end else begin
					// out-of-range link reads as zero
					c_d = '0;
					cnt_d = cnt_q + 1'b1;
				end
			end
			fct_pkg::S_CHWAIT: begin
				c_d = mem_rdata[fct_pkg::CLUS_W-1:0];
				cnt_d = cnt_q + 1'b1;
				state_d = fct_pkg::S_CHAIN;
			end
			default: begin
				state_d = fct_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != fct_pkg::S_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

endmodule

`default_nettype wire

>>> rtl/core/fct_checker.sv
// ---------------------------------------------------------------------------
// fct_checker
// Port-level checks of the cluster chain table engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fct_checker (
	input wire logic   clk,
	input wire logic   arst_n,
	input wire logic   start,
	input wire logic   busy,
	input wire logic   done,
	input fct_pkg::rsp_t rsp
);

	`FCT_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted request did not raise busy")
	`FCT_ASSERT_NXT(a_single_strobe, clk, arst_n, done, !done, "result strobe held two cycles")
	`FCT_ASSERT_IMP(a_done_after_busy, clk, arst_n, done, $past(busy), "result without a request in flight")
	`FCT_ASSERT_IMP(a_range_zero, clk, arst_n, done && rsp.status == fct_pkg::ST_RANGE, rsp.result_value == '0, "range error with nonzero result")
	`FCT_ASSERT_IMP(a_nospace_zero, clk, arst_n, done && rsp.status == fct_pkg::ST_NOSPACE, rsp.result_value == '0, "no-space status with nonzero result")

endmodule

bind fat_cluster_table_engine fct_checker u_fct_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

`default_nettype wire
